/* rtl/lru_pkg.sv */
package lru_pkg;

	localparam int LINK_W = 8;
	localparam int EIU_W = 7;

	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_CLOSE = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	typedef enum logic [1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_SKIP  = 2'd1,
		STATUS_RANGE = 2'd2
	} lru_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LINK_FIX,
		S_LINK_HEAD,
		S_READ,
		S_RESP
	} lru_state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic issue;
		logic link_fix;
		logic link_head;
		logic read;
		logic load_out;
	} lru_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic move;
		logic out_free;
	} lru_stat_t;

	// A link names a list member when it is non-negative and below the entry count.
	function automatic logic in_list(input logic [LINK_W-1:0] v, input logic [EIU_W-1:0] eiu);
		return !v[LINK_W-1] && (v[EIU_W-1:0] < eiu);
	endfunction

endpackage

/* rtl/lru_in_if.sv */
interface lru_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [5:0]  entry_index;
	logic [15:0] owner_id;
	logic [31:0] now_time;
	logic        skip_special;

	modport source (
		output valid, command, entry_index, owner_id, now_time, skip_special,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, owner_id, now_time, skip_special,
		output ready
	);
endinterface

/* rtl/lru_out_if.sv */
interface lru_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [5:0]         head_index;
	logic [5:0]         tail_index;
	logic signed [16:0] entry_owner;
	logic [31:0]        entry_time;
	logic signed [7:0]  entry_prev;
	logic signed [7:0]  entry_next;

	modport source (
		output valid, status, head_index, tail_index, entry_owner, entry_time,
		       entry_prev, entry_next,
		input  ready
	);
	modport sink (
		input  valid, status, head_index, tail_index, entry_owner, entry_time,
		       entry_prev, entry_next,
		output ready
	);
endinterface

/* rtl/lru_mem.sv */
module lru_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	output logic                     rvalid
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rdata_q;
	logic             rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Reads return the contents from before a write in the same cycle.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q  <= mem_q[raddr];
			rvalid_q <= vld_q[raddr];
		end
	end

	// An entry that is not marked valid has not been written since reset or clear; it reads back with rvalid low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;

endmodule

/* rtl/lru_ctrl.sv */
module lru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  lru_pkg::lru_stat_t stat,
	output logic              item_ready,
	output lru_pkg::lru_cmd_t  cmd
);

	lru_pkg::lru_state_t state_q;
	lru_pkg::lru_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lru_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = stat.move ? lru_pkg::S_LINK_FIX : lru_pkg::S_READ;
				end
			end
			lru_pkg::S_LINK_FIX:  state_d = lru_pkg::S_LINK_HEAD;
			lru_pkg::S_LINK_HEAD: state_d = lru_pkg::S_RESP;
			lru_pkg::S_READ:      state_d = lru_pkg::S_RESP;
			lru_pkg::S_RESP: begin
				if (stat.out_free) begin
					state_d = lru_pkg::S_IDLE;
				end
			end
			default: state_d = lru_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		case (state_q)
			lru_pkg::S_IDLE: begin
				item_ready = 1'b1;
				cmd.issue  = item_valid;
			end
			lru_pkg::S_LINK_FIX: begin
				cmd.link_fix = 1'b1;
			end
			lru_pkg::S_LINK_HEAD: begin
				cmd.link_head = 1'b1;
				cmd.read      = 1'b1;
			end
			lru_pkg::S_READ: begin
				cmd.read = 1'b1;
			end
			lru_pkg::S_RESP: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/lru_dp.sv */
module lru_dp #(
	parameter int MAX_ENTRIES = 64,
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [6:0]         cfg_data,
	input  lru_pkg::lru_cmd_t   cmd,
	output lru_pkg::lru_stat_t  stat,
	input  logic [1:0]         command,
	input  logic [5:0]         entry_index,
	input  logic [15:0]        owner_id,
	input  logic [31:0]        now_time,
	input  logic               skip_special,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         status,
	output logic [5:0]         head_index,
	output logic [5:0]         tail_index,
	output logic signed [16:0] entry_owner,
	output logic [31:0]        entry_time,
	output logic signed [7:0]  entry_prev,
	output logic signed [7:0]  entry_next
);

	// Items address at most 64 entries and the list holds at most 127, so
	// entries past 127 never join the list and are not stored.
	localparam int DEPTH = (MAX_ENTRIES < 128) ? MAX_ENTRIES : 128;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = lru_pkg::LINK_W;
	localparam logic [6:0] EIU_RST = 7'((MAX_ENTRIES < 64) ? MAX_ENTRIES : 64);
	localparam logic [6:0] TAIL_RST = EIU_RST - 7'd1;

	logic [6:0]    eiu_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;

	logic [AW-1:0]        self_q;
	lru_pkg::lru_status_t  status_q;
	logic                 in_table_q;

	logic                 res_valid_q;
	lru_pkg::lru_status_t  res_status_q;
	logic [5:0]           res_head_q;
	logic [5:0]           res_tail_q;
	logic [16:0]          res_owner_q;
	logic [31:0]          res_time_q;
	logic [7:0]           res_prev_q;
	logic [7:0]           res_next_q;

	logic [6:0]    cfg_sat;
	logic [6:0]    cfg_m1;
	logic [AW+5:0] idx_ext;
	logic [AW-1:0] self_a;
	logic          in_range;
	logic          in_table;
	logic          skip_hit;
	logic          is_access;
	logic          is_close;
	logic          do_access;
	logic          do_close;
	logic          move;
	lru_pkg::lru_status_t issue_status;

	logic [LW-1:0] self8;
	logic [LW-1:0] head8;
	logic [LW-1:0] eiu8;
	logic [LW-1:0] next_rd;
	logic [LW-1:0] prev_rd;
	logic          next_rv;
	logic          prev_rv;
	logic [LW-1:0] next_val;
	logic [LW-1:0] prev_val;
	logic          fix_tail;

	logic          next_we;
	logic [AW-1:0] next_waddr;
	logic [LW-1:0] next_wdata;
	logic          prev_we;
	logic [AW-1:0] prev_waddr;
	logic [LW-1:0] prev_wdata;
	logic          link_re;
	logic [AW-1:0] link_raddr;
	logic          field_re;

	logic                    owner_we;
	logic [16:0]             owner_wdata;
	logic [16:0]             owner_rd;
	logic                    owner_rv;
	logic                    time_we;
	logic [TIME_BITS+31:0]   now_ext;
	logic [TIME_BITS-1:0]    time_rd;
	logic                    time_rv;
	logic [TIME_BITS+31:0]   time_ext;

	logic [AW+5:0] head_ext;
	logic [AW+5:0] tail_ext;

	// Configuration value clamped to the supported entry count.
	always_comb begin
		if (cfg_data < 7'd2) begin
			cfg_sat = 7'd2;
		end else if ({25'd0, cfg_data} > 32'(MAX_ENTRIES)) begin
			cfg_sat = 7'(MAX_ENTRIES);
		end else begin
			cfg_sat = cfg_data;
		end
		cfg_m1 = cfg_sat - 7'd1;
	end

	// Item decode, taken from the input channel in the cycle of its beat.
	always_comb begin
		idx_ext  = {{AW{1'b0}}, entry_index};
		self_a   = idx_ext[AW-1:0];
		in_range = {1'b0, entry_index} < eiu_q;
		in_table = {26'd0, entry_index} < 32'(MAX_ENTRIES);
		is_access = 1'b0;
		is_close  = 1'b0;
		case (command)
			lru_pkg::CMD_ACCESS: is_access = 1'b1;
			lru_pkg::CMD_CLOSE:  is_close  = 1'b1;
			lru_pkg::CMD_READ:   is_access = 1'b0;
			default:             is_access = 1'b0;
		endcase
		skip_hit  = is_access && skip_special;
		do_access = is_access && !skip_special && in_range;
		do_close  = is_close && in_range;
		move      = do_access && (self_a != head_q) && (head_q != tail_q);
		if (skip_hit) begin
			issue_status = lru_pkg::STATUS_SKIP;
		end else if (!in_range) begin
			issue_status = lru_pkg::STATUS_RANGE;
		end else begin
			issue_status = lru_pkg::STATUS_DONE;
		end
	end

	assign stat.move     = move;
	assign stat.out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			self_q     <= self_a;
			status_q   <= issue_status;
			in_table_q <= in_table;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eiu_q  <= EIU_RST;
			head_q <= '0;
			tail_q <= TAIL_RST[AW-1:0];
		end else if (cfg_write) begin
			eiu_q  <= cfg_sat;
			head_q <= '0;
			tail_q <= cfg_m1[AW-1:0];
		end else begin
			if (cmd.link_fix && fix_tail) begin
				tail_q <= prev_val[AW-1:0];
			end
			if (cmd.link_head) begin
				head_q <= self_q;
			end
		end
	end

	// Link values of the addressed entry; unwritten entries hold index plus
	// or minus one.
	always_comb begin
		self8    = {{(LW-AW){1'b0}}, self_q};
		head8    = {{(LW-AW){1'b0}}, head_q};
		eiu8     = {1'b0, eiu_q};
		next_val = next_rv ? next_rd : self8 + 8'd1;
		prev_val = prev_rv ? prev_rd : self8 - 8'd1;
		fix_tail = self_q == tail_q;
	end

	// The moved entry is relinked while its old neighbors are read, the
	// neighbors are joined next, and the old head points back last.
	always_comb begin
		next_we    = 1'b0;
		next_waddr = self_a;
		next_wdata = head8;
		if (cmd.issue && move) begin
			next_we = 1'b1;
		end else if (cmd.link_fix && lru_pkg::in_list(prev_val, eiu_q)) begin
			next_we    = 1'b1;
			next_waddr = prev_val[AW-1:0];
			next_wdata = fix_tail ? eiu8 : next_val;
		end

		prev_we    = 1'b0;
		prev_waddr = self_a;
		prev_wdata = '1;
		if (cmd.issue && move) begin
			prev_we = 1'b1;
		end else if (cmd.link_fix && !fix_tail && lru_pkg::in_list(next_val, eiu_q)) begin
			prev_we    = 1'b1;
			prev_waddr = next_val[AW-1:0];
			prev_wdata = prev_val;
		end else if (cmd.link_head && lru_pkg::in_list(head8, eiu_q)) begin
			prev_we    = 1'b1;
			prev_waddr = head_q;
			prev_wdata = self8;
		end

		field_re   = cmd.read && in_table_q;
		link_re    = (cmd.issue && move) || field_re;
		link_raddr = cmd.issue ? self_a : self_q;
	end

	always_comb begin
		owner_we    = cmd.issue && (do_access || do_close);
		owner_wdata = do_access ? {1'b0, owner_id} : '1;
		time_we     = cmd.issue && do_access;
		now_ext     = {{TIME_BITS{1'b0}}, now_time};
	end

	lru_mem #(.DEPTH(DEPTH), .WIDTH(LW)) u_next_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_write),
		.we     (next_we),
		.waddr  (next_waddr),
		.wdata  (next_wdata),
		.re     (link_re),
		.raddr  (link_raddr),
		.rdata  (next_rd),
		.rvalid (next_rv)
	);

	lru_mem #(.DEPTH(DEPTH), .WIDTH(LW)) u_prev_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_write),
		.we     (prev_we),
		.waddr  (prev_waddr),
		.wdata  (prev_wdata),
		.re     (link_re),
		.raddr  (link_raddr),
		.rdata  (prev_rd),
		.rvalid (prev_rv)
	);

	lru_mem #(.DEPTH(DEPTH), .WIDTH(17)) u_owner_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_write),
		.we     (owner_we),
		.waddr  (self_a),
		.wdata  (owner_wdata),
		.re     (field_re),
		.raddr  (self_q),
		.rdata  (owner_rd),
		.rvalid (owner_rv)
	);

	lru_mem #(.DEPTH(DEPTH), .WIDTH(TIME_BITS)) u_time_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_write),
		.we     (time_we),
		.waddr  (self_a),
		.wdata  (now_ext[TIME_BITS-1:0]),
		.re     (field_re),
		.raddr  (self_q),
		.rdata  (time_rd),
		.rvalid (time_rv)
	);

	always_comb begin
		head_ext = {6'd0, head_q};
		tail_ext = {6'd0, tail_q};
		time_ext = {32'd0, time_rd};
	end

	// Output register; an entry outside the table reports no owner and zeros.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_status_q <= status_q;
			res_head_q   <= head_ext[5:0];
			res_tail_q   <= tail_ext[5:0];
			if (in_table_q) begin
				res_owner_q <= owner_rv ? owner_rd : '1;
				res_time_q  <= time_rv ? time_ext[31:0] : '0;
				res_prev_q  <= prev_val;
				res_next_q  <= next_val;
			end else begin
				res_owner_q <= '1;
				res_time_q  <= '0;
				res_prev_q  <= '0;
				res_next_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = res_status_q;
	assign head_index  = res_head_q;
	assign tail_index  = res_tail_q;
	assign entry_owner = res_owner_q;
	assign entry_time  = res_time_q;
	assign entry_prev  = res_prev_q;
	assign entry_next  = res_next_q;

endmodule

/* rtl/lru_move_to_front_list.sv */
// Recency list over a table of entries, kept as a doubly linked list in link
// memories with the most recently used entry at the head.
// Channels: "item" carries one command beat (access, close or read) for one
// entry; "result" returns one beat per item with the list ends and the
// addressed entry's owner, time stamp and links after the command.
// cfg_write with cfg_data sets the entry count and relinks the list in index
// order; write it only while no item is in progress.
// A moving access passes the neighbor relink, head relink and response states
// before its result enters the output register; other items pass the read and
// response states. A new item is taken only once the previous result is loaded.
// The moving access is paced by the single write port of the previous-link
// memory, which takes three updates, and by the registered read-back.
// Reset relinks the list at once: per-entry valid bits make unwritten entries
// read as their reset values, so there is no clearing pass.
// When the receiver stalls, the result waits in the output register while
// the next item is taken and worked; its result waits until the register
// frees, and only then is another item taken.
module lru_move_to_front_list #(
	parameter int MAX_ENTRIES = 64,
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [6:0]  cfg_data,
	lru_in_if.sink      item,
	lru_out_if.source   result
);

	lru_pkg::lru_cmd_t  cmd;
	lru_pkg::lru_stat_t stat;

	lru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.stat       (stat),
		.item_ready (item.ready),
		.cmd        (cmd)
	);

	lru_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.command      (item.command),
		.entry_index  (item.entry_index),
		.owner_id     (item.owner_id),
		.now_time     (item.now_time),
		.skip_special (item.skip_special),
		.res_valid    (result.valid),
		.res_ready    (result.ready),
		.status       (result.status),
		.head_index   (result.head_index),
		.tail_index   (result.tail_index),
		.entry_owner  (result.entry_owner),
		.entry_time   (result.entry_time),
		.entry_prev   (result.entry_prev),
		.entry_next   (result.entry_next)
	);

`ifndef NO_ASSERTIONS
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.issue, cmd.link_fix, cmd.link_head, cmd.load_out}))
		else $error("more than one sequencer phase active");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("item taken while the previous one is in progress");

	a_fix_then_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link_fix |=> cmd.link_head)
		else $error("neighbor relink not followed by head relink");

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!result.valid || result.ready))
		else $error("output register overwritten before its beat");
`endif

endmodule
